FILE: hdl/dgsp_pkg.sv
// shared types and constants for the dense graph shortest path block
// no dependencies
package dgsp_pkg;

  // default sizes, handed to the top level parameters
  localparam int unsigned MaxNodesDef   = 16;
  localparam int unsigned WeightBitsDef = 16;

  // fixed field widths of the beats
  localparam int unsigned NodeFieldW   = 4;
  localparam int unsigned WeightFieldW = 16;
  localparam int unsigned DistW        = 20;
  localparam int unsigned StepW        = 4;

  // configuration register
  localparam int unsigned NodeCountW   = 5;
  localparam logic [NodeCountW-1:0] NodeCountRst = 5'd16;
  localparam int unsigned ApbAddrW     = 3;
  localparam int unsigned ApbDataW     = 32;
  localparam logic [ApbAddrW-3:0] RegIdxNodeCount = '0;

  typedef struct packed {
    logic [NodeFieldW-1:0]   from_node;
    logic [NodeFieldW-1:0]   to_node;
    logic [WeightFieldW-1:0] weight;
    logic                    last_edge;
  } edge_t;

  typedef struct packed {
    logic [NodeFieldW-1:0] node;
    logic [DistW-1:0]      distance;
    logic                  reachable;
    logic [StepW-1:0]      settle_step;
    logic                  last;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic load;
    logic init;
    logic scan;
    logic pick;
    logic relax;
    logic idx_clr;
    logic idx_inc;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_done;
    logic idx_end;
    logic found;
    logic round_last;
  } ctrl_sts_t;

endpackage

FILE: hdl/dgsp_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module dgsp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/dgsp_ctrl.sv
// sequencer for load, clear and the settle/relax rounds
// depends on dgsp_pkg
module dgsp_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 last_edge_i,
  input  dgsp_pkg::ctrl_sts_t  sts_i,
  output dgsp_pkg::ctrl_cmd_t  cmd_o,
  output logic                 busy_o
);

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_LOAD  = 8'b0000_0010,
    ST_INIT  = 8'b0000_0100,
    ST_SCAN  = 8'b0000_1000,
    ST_SWAIT = 8'b0001_0000,
    ST_PICK  = 8'b0010_0000,
    ST_RELAX = 8'b0100_0000,
    ST_RWAIT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (sts_i.clr_done) state_d = ST_LOAD;
      ST_LOAD:  if (start_i && last_edge_i) state_d = ST_INIT;
      ST_INIT:  state_d = ST_SCAN;
      ST_SCAN:  if (sts_i.idx_end) state_d = ST_SWAIT;
      ST_SWAIT: state_d = ST_PICK;
      ST_PICK: begin
        if (sts_i.round_last) begin
          state_d = ST_CLEAR;
        end else if (sts_i.found) begin
          state_d = ST_RELAX;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_RELAX: if (sts_i.idx_end) state_d = ST_RWAIT;
      ST_RWAIT: state_d = ST_SCAN;
      default:  state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    cmd_o.clear   = (state_q == ST_CLEAR);
    cmd_o.load    = (state_q == ST_LOAD);
    cmd_o.init    = (state_q == ST_INIT);
    cmd_o.scan    = (state_q == ST_SCAN);
    cmd_o.pick    = (state_q == ST_PICK);
    cmd_o.relax   = (state_q == ST_RELAX);
    cmd_o.idx_inc = (state_q == ST_SCAN) || (state_q == ST_RELAX);
    cmd_o.idx_clr = (state_q == ST_INIT) || (state_q == ST_SWAIT) ||
                    (state_q == ST_PICK) || (state_q == ST_RWAIT);
  end

  assign busy_o = (state_q != ST_LOAD);

endmodule

FILE: hdl/dgsp_dp.sv
// datapath: edge store with min-merge load pipe, label store, scan and relax stages
// depends on dgsp_pkg and dgsp_ram
module dgsp_dp #(
  parameter int unsigned MaxNodes   = dgsp_pkg::MaxNodesDef,
  parameter int unsigned WeightBits = dgsp_pkg::WeightBitsDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  dgsp_pkg::ctrl_cmd_t             cmd_i,
  output dgsp_pkg::ctrl_sts_t             sts_o,
  input  logic                            start_i,
  input  dgsp_pkg::edge_t                 edge_i,
  input  logic [dgsp_pkg::NodeCountW-1:0] node_count_i,
  output logic                            res_valid_o,
  output dgsp_pkg::result_t               res_o
);

  localparam int unsigned NodeW     = $clog2(MaxNodes);
  localparam int unsigned EdgeAw    = 2 * NodeW;
  localparam int unsigned EdgeDepth = 1 << EdgeAw;
  localparam int unsigned EdgeW     = WeightBits + 1;
  localparam int unsigned LabelW    = WeightBits + NodeW;

  // node count clamp
  logic [NodeW-1:0] nlast_cfg;
  always_comb begin
    if (node_count_i == '0) begin
      nlast_cfg = '0;
    end else if (int'(node_count_i) > int'(MaxNodes)) begin
      nlast_cfg = NodeW'(MaxNodes - 1);
    end else begin
      nlast_cfg = NodeW'(node_count_i - 1'b1);
    end
  end

  // edge load
  logic              in_ok, ld_ok;
  logic [NodeW-1:0]  in_from, in_to;
  logic [EdgeAw-1:0] in_addr;
  logic [WeightBits-1:0] in_w;

  assign in_ok   = (int'(edge_i.from_node) < int'(MaxNodes)) &&
                   (int'(edge_i.to_node) < int'(MaxNodes));
  assign ld_ok   = cmd_i.load && start_i && in_ok;
  assign in_from = NodeW'(edge_i.from_node);
  assign in_to   = NodeW'(edge_i.to_node);
  assign in_addr = {in_from, in_to};
  assign in_w    = WeightBits'(edge_i.weight);

  logic                  ld_vld_q, ld_fwd_q;
  logic [EdgeAw-1:0]     ld_addr_q;
  logic [WeightBits-1:0] ld_w_q;
  logic [EdgeW-1:0]      ld_fwd_val_q;
  logic [EdgeW-1:0]      edge_rdata, ld_old, ld_merged;

  assign ld_old    = ld_fwd_q ? ld_fwd_val_q : edge_rdata;
  assign ld_merged = (!ld_old[WeightBits] || (ld_w_q < ld_old[WeightBits-1:0])) ?
                     {1'b1, ld_w_q} : ld_old;

  // scan, pick and relax state
  logic [EdgeAw-1:0]     clr_q;
  logic [NodeW-1:0]      v_q, nlast_q, k_q, pick_q;
  logic [MaxNodes-1:0]   valid_q, settled_q;
  logic                  s_vld_q, r_vld_q;
  logic [NodeW-1:0]      s_idx_q, r_idx_q;
  logic                  found_q, first_found_q;
  logic [NodeW-1:0]      best_idx_q, first_idx_q;
  logic [LabelW-1:0]     best_lab_q, pick_lab_q;
  logic                  res_vld_q;
  dgsp_pkg::result_t     res_q;

  // edge store
  logic              edge_we;
  logic [EdgeAw-1:0] edge_waddr, edge_raddr;
  logic [EdgeW-1:0]  edge_wdata;

  assign edge_we    = cmd_i.clear || ld_vld_q;
  assign edge_waddr = cmd_i.clear ? clr_q : ld_addr_q;
  assign edge_wdata = cmd_i.clear ? '0 : ld_merged;
  assign edge_raddr = cmd_i.load ? in_addr : {pick_q, v_q};

  dgsp_ram #(
    .Width (EdgeW),
    .Depth (EdgeDepth)
  ) u_edge_ram (
    .clk_i   (clk_i),
    .we_i    (edge_we),
    .waddr_i (edge_waddr),
    .wdata_i (edge_wdata),
    .raddr_i (edge_raddr),
    .rdata_o (edge_rdata)
  );

  // label store
  logic [LabelW-1:0] lab_rdata, cand, lab_wdata;
  logic [NodeW-1:0]  lab_waddr;
  logic              lab_we, s_free, s_take, r_upd;

  assign cand = pick_lab_q + LabelW'(edge_rdata[WeightBits-1:0]);
  assign r_upd = r_vld_q && !settled_q[r_idx_q] && edge_rdata[WeightBits] &&
                 (!valid_q[r_idx_q] || (cand < lab_rdata));
  assign s_free = s_vld_q && !settled_q[s_idx_q];
  assign s_take = s_free && valid_q[s_idx_q] && (!found_q || (lab_rdata < best_lab_q));

  assign lab_we    = cmd_i.init || r_upd;
  assign lab_waddr = cmd_i.init ? '0 : r_idx_q;
  assign lab_wdata = cmd_i.init ? '0 : cand;

  dgsp_ram #(
    .Width (LabelW),
    .Depth (MaxNodes)
  ) u_label_ram (
    .clk_i   (clk_i),
    .we_i    (lab_we),
    .waddr_i (lab_waddr),
    .wdata_i (lab_wdata),
    .raddr_i (v_q),
    .rdata_o (lab_rdata)
  );

  logic [NodeW-1:0] pick_idx;
  assign pick_idx = found_q ? best_idx_q : first_idx_q;

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_vld_q      <= 1'b0;
      clr_q         <= '0;
      v_q           <= '0;
      nlast_q       <= '0;
      k_q           <= '0;
      pick_q        <= '0;
      valid_q       <= '0;
      settled_q     <= '0;
      s_vld_q       <= 1'b0;
      r_vld_q       <= 1'b0;
      found_q       <= 1'b0;
      first_found_q <= 1'b0;
      res_vld_q     <= 1'b0;
    end else begin
      ld_vld_q  <= ld_ok;
      s_vld_q   <= cmd_i.scan;
      r_vld_q   <= cmd_i.relax;
      res_vld_q <= cmd_i.pick;
      if (cmd_i.clear) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cmd_i.idx_clr) begin
        v_q <= '0;
      end else if (cmd_i.idx_inc) begin
        v_q <= v_q + 1'b1;
      end
      if (cmd_i.init) begin
        nlast_q       <= nlast_cfg;
        k_q           <= '0;
        pick_q        <= '0;
        valid_q       <= MaxNodes'(1);
        settled_q     <= '0;
        found_q       <= 1'b0;
        first_found_q <= 1'b0;
      end else if (cmd_i.pick) begin
        k_q                 <= k_q + 1'b1;
        pick_q              <= pick_idx;
        settled_q[pick_idx] <= 1'b1;
        found_q             <= 1'b0;
        first_found_q       <= 1'b0;
      end else begin
        if (s_take) begin
          found_q <= 1'b1;
        end
        if (s_free) begin
          first_found_q <= 1'b1;
        end
        if (r_upd) begin
          valid_q[r_idx_q] <= 1'b1;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    s_idx_q <= v_q;
    r_idx_q <= v_q;
    if (ld_ok) begin
      ld_addr_q    <= in_addr;
      ld_w_q       <= in_w;
      ld_fwd_q     <= ld_vld_q && (ld_addr_q == in_addr);
      ld_fwd_val_q <= ld_merged;
    end
    if (s_take) begin
      best_idx_q <= s_idx_q;
      best_lab_q <= lab_rdata;
    end
    if (s_free && !first_found_q) begin
      first_idx_q <= s_idx_q;
    end
    if (cmd_i.pick) begin
      pick_lab_q        <= best_lab_q;
      res_q.node        <= dgsp_pkg::NodeFieldW'(pick_idx);
      res_q.distance    <= found_q ? dgsp_pkg::DistW'(best_lab_q) : '0;
      res_q.reachable   <= found_q;
      res_q.settle_step <= dgsp_pkg::StepW'(k_q);
      res_q.last        <= (k_q == nlast_q);
    end
  end

  assign sts_o.clr_done   = &clr_q;
  assign sts_o.idx_end    = (v_q == nlast_q);
  assign sts_o.found      = found_q;
  assign sts_o.round_last = (k_q == nlast_q);

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

endmodule

FILE: hdl/dense_graph_shortest_paths.sv
// edge load: one edge beat per cycle while busy is low; an edge with last_edge set starts a solve
// solve of n nodes: an init step, then per round a scan of all n nodes, a wait and a pick, and
// a relax pass over the n nodes and a wait unless the pick is unreachable or final; the first
// result follows the first pick; after the solve, and after reset, a clearing pass sweeps all
// 4^clog2(MAX_NODES) edge ram entries (256 by default), one per cycle; busy is high throughout
// results are one-cycle strobes that the receiver cannot stall; reset is async, active low
//
// top level: apb config register, controller and datapath; depends on dgsp_pkg, dgsp_ctrl, dgsp_dp
module dense_graph_shortest_paths #(
  parameter int unsigned MaxNodes   = dgsp_pkg::MaxNodesDef,
  parameter int unsigned WeightBits = dgsp_pkg::WeightBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // edge beats
  input  logic                          start,
  output logic                          busy,
  input  dgsp_pkg::edge_t               edge_i,
  // result beats
  output logic                          res_valid_o,
  output dgsp_pkg::result_t             res_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dgsp_pkg::ApbAddrW-1:0] paddr,
  input  logic [dgsp_pkg::ApbDataW-1:0] pwdata,
  output logic [dgsp_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  // node count register, word index taken above the byte offset
  logic [dgsp_pkg::NodeCountW-1:0] node_count_q;
  logic                            reg_hit;

  assign reg_hit = (paddr[dgsp_pkg::ApbAddrW-1:2] == dgsp_pkg::RegIdxNodeCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dgsp_pkg::NodeCountRst;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count_q <= pwdata[dgsp_pkg::NodeCountW-1:0];
    end
  end

  assign prdata = reg_hit ? dgsp_pkg::ApbDataW'(node_count_q) : '0;
  assign pready = 1'b1;

  // controller and datapath talk only through these
  dgsp_pkg::ctrl_cmd_t cmd;
  dgsp_pkg::ctrl_sts_t sts;

  dgsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_edge_i (edge_i.last_edge),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  // edge ram holds present bit and weight per (from, to); label ram per node
  dgsp_dp #(
    .MaxNodes   (MaxNodes),
    .WeightBits (WeightBits)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_i      (start),
    .edge_i       (edge_i),
    .node_count_i (node_count_q),
    .res_valid_o  (res_valid_o),
    .res_o        (res_o)
  );

endmodule

FILE: hdl/dgsp_checker.sv
// port level checks for the shortest path block, bound to the top level
// depends on dgsp_pkg and dense_graph_shortest_paths
module dgsp_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input dgsp_pkg::edge_t   edge_i,
  input logic              res_valid_o,
  input dgsp_pkg::result_t res_o
);

  // results only come out during a solve
  a_res_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result beat while not busy");

  // the final edge beat starts the solve at once
  a_last_edge_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && edge_i.last_edge) |=> busy)
    else $error("no solve after final edge beat");

  // an ordinary edge beat leaves the block ready and silent
  a_edge_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && !edge_i.last_edge) |=> (!busy && !res_valid_o))
    else $error("ordinary edge beat disturbed the block");

  // result beats never come back to back
  a_res_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("back to back result beats");

  // the source settles first at distance zero
  a_source_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.settle_step == '0)) |->
      ((res_o.node == '0) && res_o.reachable && (res_o.distance == '0)))
    else $error("first result is not the source");

endmodule

bind dense_graph_shortest_paths dgsp_checker u_dgsp_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .edge_i      (edge_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

FILE: tb/dgsp_tb_pkg.sv
`timescale 1ns / 1ps
// scoreboard for the dense graph shortest path testbench: edge store, solve and expected beats
// depends on dgsp_pkg
package dgsp_tb_pkg;
  import dgsp_pkg::*;

  localparam int unsigned Nodes = MaxNodesDef;

  class settle_board;
    bit                      edge_seen [Nodes*Nodes];
    logic [WeightFieldW-1:0] edge_wt [Nodes*Nodes];
    logic [NodeCountW-1:0]   node_count;
    result_t                 settle_q [$];
    int unsigned             errors;
    int unsigned             edges_in;
    int unsigned             graphs;
    int unsigned             results_seen;

    function new();
      node_count   = NodeCountRst;
      errors       = 0;
      edges_in     = 0;
      graphs       = 0;
      results_seen = 0;
      clear_store();
    endfunction

    function void clear_store();
      foreach (edge_seen[i]) begin
        edge_seen[i] = 1'b0;
        edge_wt[i]   = '0;
      end
    endfunction

    function int unsigned pending();
      return settle_q.size();
    endfunction

    // settle order of one solve, pushed as expected result beats
    function void solve_paths();
      int unsigned n;
      int unsigned k;
      int unsigned v;
      int unsigned pick;
      int unsigned cand;
      int unsigned idx;
      bit          found;
      bit          labeled [Nodes];
      bit          settled [Nodes];
      int unsigned dist_lab [Nodes];
      result_t     r;
      n = 32'(node_count);
      if (n == 0) n = 1;
      if (n > Nodes) n = Nodes;
      for (v = 0; v < Nodes; v++) begin
        labeled[v]  = 1'b0;
        settled[v]  = 1'b0;
        dist_lab[v] = 0;
      end
      labeled[0] = 1'b1;
      for (k = 0; k < n; k++) begin
        found = 1'b0;
        pick  = 0;
        // least label wins, lowest index on a tie
        for (v = 0; v < n; v++) begin
          if (!settled[v] && labeled[v] && (!found || dist_lab[v] < dist_lab[pick])) begin
            pick  = v;
            found = 1'b1;
          end
        end
        // nothing labeled left: lowest unsettled index
        if (!found) begin
          for (v = n; v > 0; v--) begin
            if (!settled[v-1]) pick = v - 1;
          end
        end
        settled[pick] = 1'b1;
        if (found) begin
          for (v = 0; v < n; v++) begin
            idx = pick * Nodes + v;
            if (!settled[v] && edge_seen[idx]) begin
              cand = dist_lab[pick] + edge_wt[idx];
              if (!labeled[v] || cand < dist_lab[v]) begin
                dist_lab[v] = cand;
                labeled[v]  = 1'b1;
              end
            end
          end
        end
        r.node        = NodeFieldW'(pick);
        r.distance    = found ? DistW'(dist_lab[pick]) : '0;
        r.reachable   = found;
        r.settle_step = StepW'(k);
        r.last        = (k + 1 == n);
        settle_q.push_back(r);
      end
    endfunction

    // accepted edge beat: store it, solve on the last one
    function void note_edge(edge_t e);
      int unsigned idx;
      idx = int'(e.from_node) * Nodes + int'(e.to_node);
      edges_in++;
      if (!edge_seen[idx] || e.weight < edge_wt[idx]) begin
        edge_seen[idx] = 1'b1;
        edge_wt[idx]   = e.weight;
      end
      if (e.last_edge) begin
        solve_paths();
        clear_store();
        graphs++;
      end
    endfunction

    function void field_check(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    // one result beat against the oldest expectation
    function void check_settle(result_t got);
      result_t want;
      if (settle_q.size() == 0) begin
        $display("%0t: unexpected result beat, expected none, actual node %0d distance %0d",
                 $time, got.node, got.distance);
        errors++;
        return;
      end
      want = settle_q.pop_front();
      results_seen++;
      field_check("node", 32'(want.node), 32'(got.node));
      field_check("distance", 32'(want.distance), 32'(got.distance));
      field_check("reachable", 32'(want.reachable), 32'(got.reachable));
      field_check("settle_step", 32'(want.settle_step), 32'(got.settle_step));
      field_check("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// top of the dense graph shortest path testbench: clock, reset, edge and apb drivers, monitor
// depends on dgsp_pkg, dgsp_tb_pkg and the dense_graph_shortest_paths rtl
module tb_top;
  import dgsp_pkg::*;
  import dgsp_tb_pkg::*;

  localparam int unsigned RandItems   = 144;
  localparam int unsigned DrainCycles = 300;
  // register indexes and their byte addresses; index 1 holds no register
  localparam logic [ApbAddrW-3:0] RegIdxUnused  = 1'b1;
  localparam logic [ApbAddrW-1:0] AddrNodeCount = {RegIdxNodeCount, 2'b00};
  localparam logic [ApbAddrW-1:0] AddrUnused    = {RegIdxUnused, 2'b00};

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                start   = 1'b0;
  logic                busy;
  edge_t               edge_i  = '0;
  logic                res_valid_o;
  result_t             res_o;
  logic                psel    = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite  = 1'b0;
  logic [ApbAddrW-1:0] paddr   = '0;
  logic [ApbDataW-1:0] pwdata  = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  settle_board sb;
  int unsigned send_idle_pct = 0;
  int unsigned nc_writes     = 0;

  always #6 clk_i = ~clk_i;

  dense_graph_shortest_paths u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .edge_i      (edge_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // result beats are sampled mid-cycle, away from the edge that ends them
  always @(negedge clk_i) begin
    if (rst_ni && res_valid_o) sb.check_settle(res_o);
  end

  function automatic edge_t mk_edge(input int unsigned f, t, w, input bit l);
    edge_t e;
    e.from_node = NodeFieldW'(f);
    e.to_node   = NodeFieldW'(t);
    e.weight    = WeightFieldW'(w);
    e.last_edge = l;
    return e;
  endfunction

  // all tasks start and end just after a rising edge
  // one edge beat; start stays high so back-to-back beats need no gap
  task automatic send_edge(input edge_t e);
    while ($urandom_range(99) < send_idle_pct) begin
      // idle cycle with junk on the bus, the block must ignore it
      start  <= 1'b0;
      edge_i <= mk_edge($urandom_range(15), $urandom_range(15), $urandom_range(65535),
                        $urandom_range(1) == 1);
      @(posedge clk_i);
    end
    start  <= 1'b1;
    edge_i <= e;
    forever begin
      @(negedge clk_i);
      if (!busy) begin
        // beat taken at the coming edge
        sb.note_edge(e);
        @(posedge clk_i);
        break;
      end
      @(posedge clk_i);
    end
  endtask

  // drop start, let every expected beat arrive and the clearing pass finish
  task automatic wait_idle();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    do @(negedge clk_i); while (busy);
    @(posedge clk_i);
  endtask

  task automatic apb_write(input logic [ApbAddrW-1:0] addr, input logic [ApbDataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic apb_read_check(input logic [ApbAddrW-1:0] addr,
                                input logic [NodeCountW-1:0] want);
    logic [ApbDataW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(negedge clk_i); while (!pready);
    got = prdata;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got[NodeCountW-1:0] !== want) begin
      $display("%0t: node_count readback mismatch, expected %0d, actual %0d",
               $time, want, got[NodeCountW-1:0]);
      sb.errors++;
    end
  endtask

  // upper data bits are random, only the low field counts
  task automatic set_node_count(input logic [NodeCountW-1:0] v);
    logic [ApbDataW-1:0] data;
    wait_idle();
    data                 = $urandom;
    data[NodeCountW-1:0] = v;
    apb_write(AddrNodeCount, data);
    sb.node_count = v;
    nc_writes++;
    apb_read_check(AddrNodeCount, v);
  endtask

  // a write to an address with no register must leave node_count alone
  task automatic poke_unused();
    apb_write(AddrUnused, $urandom);
    apb_read_check(AddrNodeCount, sb.node_count);
  endtask

  initial begin
    int unsigned phase;
    int unsigned phase_end;
    int unsigned base;
    int unsigned n_eff;
    int unsigned n_edges;
    int unsigned j;
    int unsigned f;
    int unsigned t;
    int unsigned w;
    int unsigned r;
    bit          chain_done;
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- directed part ----
    send_idle_pct = 33;
    apb_read_check(AddrNodeCount, NodeCountRst);
    set_node_count(5'd16);
    // repeated pair keeps the least weight, weights at both extremes,
    // equal labels on nodes 1 and 2, self loops,
    // unreachable nodes in the middle
    send_edge(mk_edge(0, 1, 65535, 1'b0));
    send_edge(mk_edge(0, 1, 5, 1'b0));
    send_edge(mk_edge(0, 1, 9, 1'b0));
    send_edge(mk_edge(1, 2, 0, 1'b0));
    send_edge(mk_edge(0, 2, 5, 1'b0));
    send_edge(mk_edge(3, 3, 7, 1'b0));
    send_edge(mk_edge(2, 15, 65535, 1'b0));
    send_edge(mk_edge(15, 15, 1, 1'b0));
    send_edge(mk_edge(14, 13, 3, 1'b0));
    send_edge(mk_edge(15, 0, 65535, 1'b1));
    // single node, with an edge to a node out of use
    set_node_count(5'd1);
    send_edge(mk_edge(0, 3, 1, 1'b0));
    send_edge(mk_edge(0, 0, 0, 1'b1));
    // zero node count behaves as one
    set_node_count(5'd0);
    poke_unused();
    send_edge(mk_edge(5, 7, 100, 1'b1));
    // count above the store size behaves as the store size
    set_node_count(5'd31);
    send_edge(mk_edge(0, 15, 65535, 1'b1));
    // two nodes, the second unreachable
    set_node_count(5'd2);
    send_edge(mk_edge(1, 0, 4, 1'b1));

    // ---- random part, three idle phases ----
    base       = sb.edges_in;
    chain_done = 1'b0;
    for (phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 33 : (phase == 1) ? 79 : 0;
      phase_end     = base + (phase + 1) * RandItems / 3;
      while (sb.edges_in < phase_end) begin
        if (!chain_done) begin
          // a full chain of heaviest edges gives the largest distance
          set_node_count(5'd16);
          for (j = 0; j < 15; j++) send_edge(mk_edge(j, j + 1, 65535, j == 14));
          chain_done = 1'b1;
        end else begin
          if ($urandom_range(99) < 40) begin
            r = $urandom_range(99);
            if (r < 8) set_node_count(5'd1);
            else if (r < 12) set_node_count(5'd0);
            else if (r < 22) set_node_count(5'd16);
            else if (r < 30) set_node_count(NodeCountW'($urandom_range(31, 17)));
            else set_node_count(NodeCountW'($urandom_range(8, 2)));
            if ($urandom_range(4) == 0) poke_unused();
          end
          n_eff = 32'(sb.node_count);
          if (n_eff == 0) n_eff = 1;
          if (n_eff > Nodes) n_eff = Nodes;
          n_edges = $urandom_range(1, (2 * n_eff < 12) ? 2 * n_eff : 12);
          for (j = 0; j < n_edges; j++) begin
            // mostly edges among the nodes in use, the rest anywhere
            if ($urandom_range(99) < 85) begin
              f = $urandom_range(n_eff - 1);
              t = $urandom_range(n_eff - 1);
            end else begin
              f = $urandom_range(15);
              t = $urandom_range(15);
            end
            // small weights make ties common
            r = $urandom_range(99);
            if (r < 50) w = $urandom_range(15);
            else if (r < 90) w = $urandom_range(65535);
            else if (r < 95) w = 0;
            else w = 65535;
            send_edge(mk_edge(f, t, w, j == n_edges - 1));
          end
        end
      end
    end

    // ---- drain and verdict ----
    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    $display("covered %0d graphs from %0d edge beats, %0d result beats checked",
             sb.graphs, sb.edges_in, sb.results_seen);
    $display("node_count written %0d times, zero, one, full and oversized counts among them",
             nc_writes);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hard stop well past the slowest correct run
  initial begin
    #10_000_000;
    $display("timeout");
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: files.f
hdl/dgsp_pkg.sv
hdl/dgsp_ram.sv
hdl/dgsp_ctrl.sv
hdl/dgsp_dp.sv
hdl/dense_graph_shortest_paths.sv
hdl/dgsp_checker.sv
tb/dgsp_tb_pkg.sv
tb/tb_top.sv
